FILE: rtl/core/tcpc_pkg.sv
// Shared types, constants and codes for the terminal cursor position controller.
`timescale 1ns / 1ps
`default_nettype none

package tcpc_pkg;

  // Upper bounds on the viewport; the cursor fields are 8 bits, so neither
  // size ever goes above 256 cells.
  parameter int MAX_ROWS = 256;
  parameter int MAX_COLS = 256;
  localparam int ROW_LIMIT_INT = (MAX_ROWS < 256) ? MAX_ROWS : 256;
  localparam int COL_LIMIT_INT = (MAX_COLS < 256) ? MAX_COLS : 256;
  localparam logic [8:0] ROW_LIMIT = 9'(ROW_LIMIT_INT);
  localparam logic [8:0] COL_LIMIT = 9'(COL_LIMIT_INT);

  localparam logic [8:0] ROWS_RESET = 9'd24;
  localparam logic [8:0] COLS_RESET = 9'd80;

  typedef enum logic [1:0] {
    CFG_ROWS    = 2'd0,
    CFG_COLS    = 2'd1,
    CFG_NL_MODE = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    NL_PLAIN   = 2'd0,
    NL_CR_FEED = 2'd1,
    NL_LF_CR   = 2'd2
  } nl_mode_t;

  typedef enum logic [3:0] {
    FN_UP       = 4'd0,
    FN_DOWN     = 4'd1,
    FN_RIGHT    = 4'd2,
    FN_LEFT     = 4'd3,
    FN_SET_POS  = 4'd4,
    FN_SET_COL  = 4'd5,
    FN_SAVE     = 4'd6,
    FN_RESTORE  = 4'd7,
    FN_CR       = 4'd8,
    FN_LF       = 4'd9,
    FN_BS       = 4'd10,
    FN_POS_RPT  = 4'd11,
    FN_STATUS   = 4'd12
  } func_t;

  // The device status answer is the fixed string ESC [ 0 n.
  typedef enum logic [1:0] {
    RPT_NONE   = 2'd0,
    RPT_STATUS = 2'd1,
    RPT_POS    = 2'd2
  } report_t;

  typedef struct packed {
    logic [7:0] last_row;
    logic [7:0] last_col;
    logic [1:0] nl_mode;
  } view_t;

  typedef struct packed {
    logic [3:0]  func;
    logic [15:0] amount;
    logic        to_line_start;
    logic [15:0] target_row;
    logic [15:0] target_col;
  } cmd_t;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] saved_row;
    logic [7:0] saved_col;
  } cursor_t;

  typedef struct packed {
    logic [7:0] cursor_row;
    logic [7:0] cursor_col;
    logic       line_inserted;
    logic       line_fed;
    logic [1:0] report_kind;
    logic [8:0] report_row;
    logic [8:0] report_col;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/tcpc_cfg_regs.sv
// Configuration registers and the effective viewport bounds derived from them.
`timescale 1ns / 1ps
`default_nettype none

module tcpc_cfg_regs (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [8:0]           cfg_data,
  output tcpc_pkg::view_t           view
);

  logic [8:0] viewport_rows;
  logic [8:0] viewport_cols;
  logic [1:0] newline_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      viewport_rows <= tcpc_pkg::ROWS_RESET;
      viewport_cols <= tcpc_pkg::COLS_RESET;
      newline_mode  <= tcpc_pkg::NL_PLAIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (tcpc_pkg::cfg_index_t'(cfg_index))
        tcpc_pkg::CFG_ROWS:    viewport_rows <= cfg_data;
        tcpc_pkg::CFG_COLS:    viewport_cols <= cfg_data;
        tcpc_pkg::CFG_NL_MODE: newline_mode  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // A size of zero counts as one cell; a size above the limit saturates.
  logic [8:0] rows_eff;
  logic [8:0] cols_eff;

  always_comb begin
    if (viewport_rows == 9'd0) begin
      rows_eff = 9'd1;
    end else if (viewport_rows > tcpc_pkg::ROW_LIMIT) begin
      rows_eff = tcpc_pkg::ROW_LIMIT;
    end else begin
      rows_eff = viewport_rows;
    end
    if (viewport_cols == 9'd0) begin
      cols_eff = 9'd1;
    end else if (viewport_cols > tcpc_pkg::COL_LIMIT) begin
      cols_eff = tcpc_pkg::COL_LIMIT;
    end else begin
      cols_eff = viewport_cols;
    end
  end

  logic [8:0] last_row_w;
  logic [8:0] last_col_w;
  assign last_row_w    = rows_eff - 9'd1;
  assign last_col_w    = cols_eff - 9'd1;
  assign view.last_row = last_row_w[7:0];
  assign view.last_col = last_col_w[7:0];
  // Mode 3 has no meaning and behaves as plain mode.
  assign view.nl_mode  = (newline_mode == 2'd3) ? tcpc_pkg::NL_PLAIN : newline_mode;

endmodule

`default_nettype wire

FILE: rtl/core/tcpc_step.sv
// Next-cursor and result logic for one command.
`timescale 1ns / 1ps
`default_nettype none

module tcpc_step (
  input  wire tcpc_pkg::cmd_t    cmd,
  input  wire tcpc_pkg::cursor_t cur,
  input  wire tcpc_pkg::view_t   view,
  output tcpc_pkg::cursor_t      nxt,
  output tcpc_pkg::result_t      res
);

  logic [15:0] amt;
  logic [7:0]  row_c;
  logic [7:0]  col_c;
  logic [7:0]  row_room;
  logic [7:0]  col_room;
  logic        at_bottom;
  logic [7:0]  row_set;
  logic [7:0]  col_set;
  logic [7:0]  row_rst;
  logic [7:0]  col_rst;
  logic [7:0]  row_fwd;
  logic [7:0]  col_fwd;

  assign amt   = (cmd.amount == 16'd0) ? 16'd1 : cmd.amount;
  // A shrunk viewport pulls the live cursor in before the command acts.
  assign row_c = (cur.row > view.last_row) ? view.last_row : cur.row;
  assign col_c = (cur.col > view.last_col) ? view.last_col : cur.col;
  assign row_room  = view.last_row - row_c;
  assign col_room  = view.last_col - col_c;
  assign at_bottom = (row_c == view.last_row);
  assign row_set = (cmd.target_row > {8'd0, view.last_row}) ? view.last_row
                                                             : cmd.target_row[7:0];
  assign col_set = (cmd.target_col > {8'd0, view.last_col}) ? view.last_col
                                                             : cmd.target_col[7:0];
  assign row_rst = (cur.saved_row > view.last_row) ? view.last_row : cur.saved_row;
  assign col_rst = (cur.saved_col > view.last_col) ? view.last_col : cur.saved_col;
  assign row_fwd = at_bottom ? row_c : row_c + 8'd1;
  assign col_fwd = (col_c == 8'd0) ? 8'd0 : col_c - 8'd1;

  always_comb begin
    nxt.row       = row_c;
    nxt.col       = col_c;
    nxt.saved_row = cur.saved_row;
    nxt.saved_col = cur.saved_col;
    res.line_inserted = 1'b0;
    res.line_fed      = 1'b0;
    res.report_kind   = tcpc_pkg::RPT_NONE;
    res.report_row    = 9'd0;
    res.report_col    = 9'd0;

    unique case (tcpc_pkg::func_t'(cmd.func))
      tcpc_pkg::FN_UP: begin
        nxt.row = (amt >= {8'd0, row_c}) ? 8'd0 : row_c - amt[7:0];
      end
      tcpc_pkg::FN_DOWN: begin
        nxt.row = (amt >= {8'd0, row_room}) ? view.last_row : row_c + amt[7:0];
      end
      tcpc_pkg::FN_RIGHT: begin
        nxt.col = (amt >= {8'd0, col_room}) ? view.last_col : col_c + amt[7:0];
      end
      tcpc_pkg::FN_LEFT: begin
        nxt.col = (amt >= {8'd0, col_c}) ? 8'd0 : col_c - amt[7:0];
      end
      tcpc_pkg::FN_SET_POS: begin
        nxt.row = row_set;
        nxt.col = col_set;
      end
      tcpc_pkg::FN_SET_COL: begin
        nxt.col = col_set;
      end
      tcpc_pkg::FN_SAVE: begin
        nxt.saved_row = row_c;
        nxt.saved_col = col_c;
      end
      tcpc_pkg::FN_RESTORE: begin
        nxt.row = row_rst;
        nxt.col = col_rst;
      end
      tcpc_pkg::FN_CR: begin
        if (view.nl_mode == tcpc_pkg::NL_CR_FEED) begin
          nxt.row           = row_fwd;
          res.line_inserted = at_bottom;
        end
        nxt.col = 8'd0;
      end
      tcpc_pkg::FN_LF: begin
        nxt.row           = row_fwd;
        res.line_inserted = at_bottom;
        res.line_fed      = 1'b1;
        if (view.nl_mode == tcpc_pkg::NL_LF_CR) begin
          nxt.col = 8'd0;
        end
      end
      tcpc_pkg::FN_BS: begin
        nxt.col = col_fwd;
      end
      tcpc_pkg::FN_POS_RPT: begin
        res.report_kind = tcpc_pkg::RPT_POS;
        res.report_row  = {1'b0, row_c} + 9'd1;
        res.report_col  = {1'b0, col_c} + 9'd1;
      end
      tcpc_pkg::FN_STATUS: begin
        res.report_kind = tcpc_pkg::RPT_STATUS;
      end
      default: ;
    endcase

    // The line start flag only applies to the four relative moves.
    if (cmd.func <= tcpc_pkg::FN_LEFT && cmd.to_line_start) begin
      nxt.col = 8'd0;
    end

    res.cursor_row = nxt.row;
    res.cursor_col = nxt.col;
  end

endmodule

`default_nettype wire

FILE: rtl/core/terminal_cursor_position_controller.sv
// Top level of the terminal cursor position controller: registers and handshakes.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// Each input beat on the command channel (in_valid / in_stall) carries one
// decoded terminal command: func, amount, to_line_start, target_row and
// target_col. Every command produces exactly one result beat on the output
// channel (out_valid / out_stall) with the cursor after the command, the
// line feed and scroll flags, and an optional status or position report.
// The viewport size and newline mode are written over the cfg_valid /
// cfg_ready channel, which is always ready; write it only while idle.
// An accepted command is first held in the command register; the cursor
// update and the result then land in the result register together, and
// out_valid rises with them. Throughput is one command per cycle while the
// receiver does not stall, set by the single cursor update path between the
// command and result registers.
// When the receiver stalls, the result register holds its beat, the command
// register holds the next command, and in_stall rises while both are full
// and out_stall is high.
// Synchronous reset clears the cursor and saved position to row 0, col 0,
// restores a 24 by 80 viewport in plain newline mode, and empties both
// registers.
module terminal_cursor_position_controller (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  func,
  input  wire logic [15:0] amount,
  input  wire logic        to_line_start,
  input  wire logic [15:0] target_row,
  input  wire logic [15:0] target_col,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       cursor_row,
  output logic [7:0]       cursor_col,
  output logic             line_inserted,
  output logic             line_fed,
  output logic [1:0]       report_kind,
  output logic [8:0]       report_row,
  output logic [8:0]       report_col,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);

  tcpc_pkg::view_t   view;
  tcpc_pkg::cmd_t    cmd;
  tcpc_pkg::cursor_t cursor;
  tcpc_pkg::cursor_t cursor_next;
  tcpc_pkg::result_t step_res;
  tcpc_pkg::result_t res;

  logic in_full;
  logic advance;

  tcpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .view      (view)
  );

  tcpc_step u_step (
    .cmd  (cmd),
    .cur  (cursor),
    .view (view),
    .nxt  (cursor_next),
    .res  (step_res)
  );

  // The held command moves on whenever the result register is empty or its
  // beat is being taken this cycle, so it waits only while a stalled beat is held.
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd.func          <= func;
      cmd.amount        <= amount;
      cmd.to_line_start <= to_line_start;
      cmd.target_row    <= target_row;
      cmd.target_col    <= target_col;
    end
  end

  // The cursor and saved position change only as a command retires.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else if (advance) begin
      cursor <= cursor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_res;
    end
  end

  assign cursor_row    = res.cursor_row;
  assign cursor_col    = res.cursor_col;
  assign line_inserted = res.line_inserted;
  assign line_fed      = res.line_fed;
  assign report_kind   = res.report_kind;
  assign report_row    = res.report_row;
  assign report_col    = res.report_col;

  // The command register only stalls the input while it holds a beat.
  assert property (@(posedge clk) in_stall |-> in_full)
    else $error("input stalled with an empty command register");

  // A retiring command always leaves a beat in the result register.
  assert property (@(posedge clk) disable iff (rst) advance |=> out_valid)
    else $error("retired command produced no result beat");

  // Report fields are zero unless a position report was asked for.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && report_kind != tcpc_pkg::RPT_POS) |->
      (report_row == 9'd0 && report_col == 9'd0))
    else $error("report position set without a position report");

  // A line feed never carries a report.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && line_fed) |-> (report_kind == tcpc_pkg::RPT_NONE))
    else $error("line feed result carries a report");

  // Reset puts the cursor home.
  assert property (@(posedge clk) rst |=> (cursor.row == 8'd0 && cursor.col == 8'd0))
    else $error("cursor not at home after reset");

endmodule

`default_nettype wire

FILE: test/terminal_cursor_position_controller_tb.sv
// Self-checking testbench for the terminal cursor position controller.
`timescale 1ns / 1ps

module terminal_cursor_position_controller_tb;
  import tcpc_pkg::*;

  // Command codes above FN_STATUS mean nothing to the block. It must leave the
  // cursor alone for them, so they are driven on purpose.
  localparam logic [3:0] FN_BAD_FIRST = 4'd13;
  localparam logic [3:0] FN_BAD_LAST  = 4'd15;
  // The newline register is two bits wide. Its last code is not a mode and
  // must behave like plain mode.
  localparam logic [1:0] NL_UNDEFINED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Command channel. The whole payload lives in one struct, so that a new beat
  // is a single nonblocking assignment.
  logic in_valid = 1'b0;
  logic in_stall;
  cmd_t offer = '0;

  // Result channel.
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] cursor_row;
  logic [7:0] cursor_col;
  logic       line_inserted;
  logic       line_fed;
  logic [1:0] report_kind;
  logic [8:0] report_row;
  logic [8:0] report_col;

  // Register write channel.
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  // Commands not yet offered, and results owed by the block (oldest first).
  cmd_t    commands_waiting[$];
  result_t cursor_results_due[$];

  // The testbench's own copy of the cursor, the saved position and the
  // registers. The registers change only while the block is idle.
  int         cur_row, cur_col, mark_row, mark_col;
  logic [8:0] view_rows, view_cols;
  logic [1:0] feed_mode;

  // Chance of an idle cycle per hundred on either side, and the long receiver
  // hold-off that fills the block up until it stalls its input.
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_arm = 1'b0;
  int   hold_left = 0;

  int mismatches = 0;

  terminal_cursor_position_controller u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (offer.func),
    .amount        (offer.amount),
    .to_line_start (offer.to_line_start),
    .target_row    (offer.target_row),
    .target_col    (offer.target_col),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cursor_row    (cursor_row),
    .cursor_col    (cursor_col),
    .line_inserted (line_inserted),
    .line_fed      (line_fed),
    .report_kind   (report_kind),
    .report_row    (report_row),
    .report_col    (report_col),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // A register value of zero counts as one cell. Large values saturate at
  // the package limit, which never exceeds 256.
  function automatic int usable_size(logic [8:0] size_reg, logic [8:0] cap);
    int v;
    v = int'(size_reg);
    if (v < 1) v = 1;
    if (v > int'(cap)) v = int'(cap);
    return v;
  endfunction

  // Applies one command to the cursor model and returns the result beat that
  // the block must produce for it.
  function automatic result_t advance_cursor(cmd_t c);
    result_t res;
    int last_r, last_c, span;
    res = '0;
    last_r = usable_size(view_rows, ROW_LIMIT) - 1;
    last_c = usable_size(view_cols, COL_LIMIT) - 1;
    span = (c.amount == 16'd0) ? 1 : int'(c.amount);
    // A viewport shrunk since the last command pulls the cursor inside it
    // first. The saved position is left alone until a restore.
    if (cur_row > last_r) cur_row = last_r;
    if (cur_col > last_c) cur_col = last_c;
    case (c.func)
      FN_UP:      cur_row = (span >= cur_row) ? 0 : cur_row - span;
      FN_DOWN:    cur_row = (span >= last_r - cur_row) ? last_r : cur_row + span;
      FN_RIGHT:   cur_col = (span >= last_c - cur_col) ? last_c : cur_col + span;
      FN_LEFT:    cur_col = (span >= cur_col) ? 0 : cur_col - span;
      FN_SET_POS: begin
        cur_row = (int'(c.target_row) > last_r) ? last_r : int'(c.target_row);
        cur_col = (int'(c.target_col) > last_c) ? last_c : int'(c.target_col);
      end
      FN_SET_COL: cur_col = (int'(c.target_col) > last_c) ? last_c : int'(c.target_col);
      FN_SAVE: begin
        mark_row = cur_row;
        mark_col = cur_col;
      end
      FN_RESTORE: begin
        cur_row = (mark_row > last_r) ? last_r : mark_row;
        cur_col = (mark_col > last_c) ? last_c : mark_col;
      end
      FN_CR: begin
        // In CR-feeds-line mode the row advances too. This is not a line
        // feed byte, so line_fed stays low.
        if (feed_mode == NL_CR_FEED) begin
          if (cur_row == last_r) res.line_inserted = 1'b1;
          else cur_row++;
        end
        cur_col = 0;
      end
      FN_LF: begin
        if (cur_row == last_r) res.line_inserted = 1'b1;
        else cur_row++;
        if (feed_mode == NL_LF_CR) cur_col = 0;
        res.line_fed = 1'b1;
      end
      FN_BS: if (cur_col > 0) cur_col--;
      FN_POS_RPT: begin
        res.report_kind = RPT_POS;
        res.report_row = 9'(cur_row + 1);
        res.report_col = 9'(cur_col + 1);
      end
      FN_STATUS: res.report_kind = RPT_STATUS;
      default: ;
    endcase
    // Only the relative moves honor the line start flag.
    if (c.func <= FN_LEFT && c.to_line_start) cur_col = 0;
    res.cursor_row = 8'(cur_row);
    res.cursor_col = 8'(cur_col);
    return res;
  endfunction

  // Command driver. When the current beat is accepted, its result is
  // predicted. A new beat is offered only when the channel is free, so a
  // beat that is not accepted stays on the wire unchanged.
  always @(posedge clk) begin : drive_commands
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) cursor_results_due.push_back(advance_cursor(offer));
      if (!in_valid || !in_stall) begin
        if (commands_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offer <= commands_waiting.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall. An armed hold-off keeps the output stalled until its
  // countdown runs out. Otherwise the stall is random at the current rate.
  always @(posedge clk) begin : drive_stall
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_arm) begin
      out_stall <= 1'b1;
      hold_left <= 60;
      hold_arm <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic check_field(string label, logic [15:0] want, logic [15:0] seen);
    if (want !== seen) begin
      $display("%0t: %s expected %0d, actual %0d", $time, label, want, seen);
      mismatches++;
    end
  endtask

  // Result monitor. Each accepted beat is compared with the oldest
  // prediction, one field at a time.
  always @(posedge clk) begin : watch_results
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (cursor_results_due.size() == 0) begin
        $display("%0t: result beat with none expected, expected nothing, actual row %0d col %0d",
                 $time, cursor_row, cursor_col);
        mismatches++;
      end else begin
        want = cursor_results_due.pop_front();
        check_field("cursor_row", 16'(want.cursor_row), 16'(cursor_row));
        check_field("cursor_col", 16'(want.cursor_col), 16'(cursor_col));
        check_field("line_inserted", 16'(want.line_inserted), 16'(line_inserted));
        check_field("line_fed", 16'(want.line_fed), 16'(line_fed));
        check_field("report_kind", 16'(want.report_kind), 16'(report_kind));
        check_field("report_row", 16'(want.report_row), 16'(report_row));
        check_field("report_col", 16'(want.report_col), 16'(report_col));
      end
    end
  end

  // Writes one register and mirrors it in the model once the write is taken.
  task automatic write_reg(cfg_index_t idx, logic [8:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ROWS:    view_rows = val;
      CFG_COLS:    view_cols = val;
      CFG_NL_MODE: feed_mode = val[1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Waits, with a cap, until every command has been offered, accepted and
  // answered.
  task automatic settle();
    int waited;
    waited = 0;
    while ((commands_waiting.size() != 0 || in_valid || cursor_results_due.size() != 0)
           && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
  endtask

  task automatic add_cmd(logic [3:0] f, int span, int line_start, int trow, int tcol);
    commands_waiting.push_back('{f, 16'(span), 1'(line_start), 16'(trow), 16'(tcol)});
  endtask

  // Mostly small distances, and small targets half the time, so that clamping
  // happens often. Now and then a full 16-bit value, so that every bit toggles.
  function automatic cmd_t random_cmd();
    cmd_t c;
    if ($urandom_range(9) == 0) c.func = 4'($urandom_range(FN_BAD_FIRST, FN_BAD_LAST));
    else c.func = 4'($urandom_range(FN_UP, FN_STATUS));
    case ($urandom_range(3))
      0: c.amount = '0;
      1: c.amount = 16'($urandom_range(1, 8));
      2: c.amount = 16'($urandom_range(1, 300));
      default: c.amount = 16'($urandom);
    endcase
    c.to_line_start = 1'($urandom_range(1));
    c.target_row = $urandom_range(1) ? 16'($urandom_range(0, 300)) : 16'($urandom);
    c.target_col = $urandom_range(1) ? 16'($urandom_range(0, 300)) : 16'($urandom);
    return c;
  endfunction

  // Viewport sizes lean toward small values. The extremes are zero, one, the
  // full 256 and values past the limit.
  function automatic logic [8:0] pick_view_size();
    case ($urandom_range(7))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd256;
      3: return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(2, 40));
    endcase
  endfunction

  initial begin : sequencer
    int p, k;
    view_rows = ROWS_RESET;
    view_cols = COLS_RESET;
    feed_mode = NL_PLAIN;
    cur_row = 0;
    cur_col = 0;
    mark_row = 0;
    mark_col = 0;
    send_idle_pct = 22;
    recv_stall_pct = 48;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed checks on the 24 by 80 viewport that reset leaves behind:
    // edges, a zero distance, the line start flag and unknown codes.
    add_cmd(FN_STATUS, 0, 0, 0, 0);
    add_cmd(FN_UP, 0, 0, 0, 0);
    add_cmd(FN_DOWN, 16'hFFFF, 0, 0, 0);
    add_cmd(FN_RIGHT, 16'hFFFF, 0, 0, 0);
    add_cmd(FN_POS_RPT, 0, 0, 0, 0);
    add_cmd(FN_LF, 0, 0, 0, 0);
    add_cmd(FN_LEFT, 0, 0, 0, 0);
    add_cmd(FN_BS, 0, 0, 0, 0);
    add_cmd(FN_UP, 5, 1, 0, 0);
    add_cmd(FN_BS, 0, 0, 0, 0);
    add_cmd(FN_SET_POS, 0, 1, 16'hFFFF, 16'hFFFF);
    add_cmd(FN_SAVE, 0, 0, 0, 0);
    add_cmd(FN_SET_POS, 0, 0, 2, 3);
    add_cmd(FN_SET_COL, 0, 0, 0, 16'hFFFF);
    add_cmd(FN_RESTORE, 0, 0, 0, 0);
    add_cmd(FN_CR, 0, 0, 0, 0);
    add_cmd(FN_BAD_FIRST, 3, 1, 7, 7);
    add_cmd(FN_BAD_FIRST + 4'd1, 0, 0, 0, 0);
    add_cmd(FN_BAD_LAST, 16'hFFFF, 1, 0, 0);
    settle();

    // Out-of-range sizes: the rows saturate at 256 and a zero width counts as
    // one. The undefined newline mode must act as plain mode.
    write_reg(CFG_ROWS, 9'h1FF);
    write_reg(CFG_COLS, 9'd0);
    write_reg(CFG_NL_MODE, 9'(NL_UNDEFINED));
    add_cmd(FN_POS_RPT, 0, 0, 0, 0);
    add_cmd(FN_SET_POS, 0, 0, 16'hFFFF, 16'hFFFF);
    add_cmd(FN_LF, 0, 0, 0, 0);
    add_cmd(FN_POS_RPT, 0, 0, 0, 0);
    add_cmd(FN_SAVE, 0, 0, 0, 0);
    settle();

    // Shrink the viewport under the cursor and the saved position. After that
    // CR feeds a line, including the scroll case at the bottom row.
    write_reg(CFG_ROWS, 9'd4);
    write_reg(CFG_COLS, 9'd6);
    write_reg(CFG_NL_MODE, 9'(NL_CR_FEED));
    add_cmd(FN_STATUS, 0, 0, 0, 0);
    add_cmd(FN_CR, 0, 0, 0, 0);
    add_cmd(FN_SET_POS, 0, 0, 0, 5);
    add_cmd(FN_CR, 0, 0, 0, 0);
    add_cmd(FN_RESTORE, 0, 0, 0, 0);
    settle();
    write_reg(CFG_NL_MODE, 9'(NL_LF_CR));
    add_cmd(FN_UP, 2, 0, 0, 0);
    add_cmd(FN_RIGHT, 3, 0, 0, 0);
    add_cmd(FN_LF, 0, 0, 0, 0);

    // Random phases, 50 commands each, with a fresh viewport and newline mode
    // every time. The first three idle the sender lightly and the receiver
    // heavily, the next three the other way round, and the last three not at
    // all. The seventh phase starts with a long receiver hold-off while the
    // sender keeps offering, so the block fills up and stalls its input.
    for (p = 0; p < 9; p++) begin
      settle();
      send_idle_pct = (p < 3) ? 22 : (p < 6) ? 48 : 0;
      recv_stall_pct = (p < 3) ? 48 : (p < 6) ? 22 : 0;
      if (p == 0) begin
        write_reg(CFG_ROWS, 9'd1);
        write_reg(CFG_COLS, 9'd256);
        write_reg(CFG_NL_MODE, 9'(NL_CR_FEED));
      end else if (p == 1) begin
        write_reg(CFG_ROWS, 9'd256);
        write_reg(CFG_COLS, 9'd1);
        write_reg(CFG_NL_MODE, 9'(NL_LF_CR));
      end else begin
        write_reg(CFG_ROWS, pick_view_size());
        write_reg(CFG_COLS, pick_view_size());
        write_reg(CFG_NL_MODE, 9'($urandom_range(3)));
      end
      if (p == 6) hold_arm = 1'b1;
      for (k = 0; k < 50; k++) commands_waiting.push_back(random_cmd());
    end

    settle();
    repeat (8) @(negedge clk);
    if (cursor_results_due.size() != 0) begin
      $display("%0t: results still due at the end, expected 0, actual %0d",
               $time, cursor_results_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[terminal_cursor_position_controller] OK");
    end else begin
      $display("[terminal_cursor_position_controller] ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake. A correct run takes far less time.
  initial begin : watchdog
    #2000000;
    $display("[terminal_cursor_position_controller] ERROR");
    $finish;
  end

endmodule
